/* sv/fvre_pkg.sv */
// fvre_pkg: shared constants and types for the four-voice release envelope unit.
// Holds mode, kind and register codes, reset values and the sequencer state type.
// No dependencies.
package fvre_pkg;

    // item kinds on the input channel
    localparam logic [1:0] MODE_NOTE_ON  = 2'd0;
    localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
    localparam logic [1:0] MODE_TICK     = 2'd2;

    // result kinds
    localparam logic KIND_VOLUME = 1'b0;
    localparam logic KIND_FREQ   = 1'b1;

    // register indexes (byte address 4*i)
    localparam logic [1:0] REG_RELEASE_TIME   = 2'd0;
    localparam logic [1:0] REG_REFRESH_PERIOD = 2'd1;
    localparam logic [1:0] REG_LOWEST_NOTE    = 2'd2;
    localparam logic [1:0] REG_HIGHEST_NOTE   = 2'd3;

    localparam logic [15:0] RELEASE_TIME_RST   = 16'd1000;
    localparam logic [15:0] REFRESH_PERIOD_RST = 16'd10;
    localparam logic [6:0]  LOWEST_NOTE_RST    = 7'd0;
    localparam logic [6:0]  HIGHEST_NOTE_RST   = 7'd127;

    localparam logic [3:0] FULL_VOLUME = 4'd15;
    localparam int         MAX_DRIVEN  = 4;
    localparam int         VOICES_DEF  = 4;

    // shared divider: 16-bit restoring, one quotient bit per cycle
    localparam int DIV_W     = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_ON_FREQ = 8'b0000_0010,
        S_ON_VOL  = 8'b0000_0100,
        S_DIV1    = 8'b0000_1000,
        S_RATE    = 8'b0001_0000,
        S_DIV2    = 8'b0010_0000,
        S_SET     = 8'b0100_0000,
        S_TICK    = 8'b1000_0000
    } state_t;

endpackage

/* sv/four_voice_release_envelope_unit.sv */
// four_voice_release_envelope_unit: top level of the four-voice linear release envelope.
// One sequencer around a shared 16-step restoring divider and a one-voice-a-cycle tick walk
// that stalls while a due beat waits on a full output register. Depends on fvre_pkg.
//
//  channel | ports                                   | beat
//  --------+-----------------------------------------+---------------------------------
//  input   | s_valid s_ready s_mode s_channel s_pitch| note-on, note-off or refresh tick
//  result  | m_valid m_ready m_kind m_voice m_value  | frequency request or volume
//          | m_last                                  | update, m_last on final beat
//  config  | psel penable pwrite paddr pwdata prdata | APB write/read, pready tied high
//
//  Steps: a note-on passes the accept and two result beats; a note-off passes the accept,
//  16 divider steps for the step count, a scaling step, 16 divider steps for the rate
//  and a write-back, ends after the scaling step on a silent voice and after the accept
//  off the voice range; a tick passes the accept and then visits each driven voice in
//  turn. s_ready is high only in the idle state.
//  Result beats sit in an output register; the walk stalls only when a beat is due
//  and the register is still full. Reset is synchronous on aresetn low and restores
//  register defaults and silent, non-releasing voices; no clearing pass is needed.
module four_voice_release_envelope_unit #(
    parameter int VOICES = fvre_pkg::VOICES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [3:0]  s_channel,
    input  logic [6:0]  s_pitch,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [1:0]  m_voice,
    output logic [6:0]  m_value,
    output logic        m_last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // only the first DRIVEN channels, at most four, drive voices
    localparam int DRIVEN = (VOICES < fvre_pkg::MAX_DRIVEN) ? VOICES : fvre_pkg::MAX_DRIVEN;
    localparam int IDX_W  = (DRIVEN > 1) ? $clog2(DRIVEN) : 1;
    localparam logic [3:0]       DRIVEN_CH = 4'(DRIVEN);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DRIVEN - 1);
    localparam int DW = fvre_pkg::DIV_W;
    localparam int CW = fvre_pkg::DIV_CNT_W;

    // ---------------- configuration registers ----------------
    logic [15:0] release_time_reg, refresh_period_reg;
    logic [6:0]  lowest_note_reg, highest_note_reg;
    logic        cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            release_time_reg   <= fvre_pkg::RELEASE_TIME_RST;
            refresh_period_reg <= fvre_pkg::REFRESH_PERIOD_RST;
            lowest_note_reg    <= fvre_pkg::LOWEST_NOTE_RST;
            highest_note_reg   <= fvre_pkg::HIGHEST_NOTE_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                fvre_pkg::REG_RELEASE_TIME:   release_time_reg   <= pwdata[15:0];
                fvre_pkg::REG_REFRESH_PERIOD: refresh_period_reg <= pwdata[15:0];
                fvre_pkg::REG_LOWEST_NOTE:    lowest_note_reg    <= pwdata[6:0];
                fvre_pkg::REG_HIGHEST_NOTE:   highest_note_reg   <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            fvre_pkg::REG_RELEASE_TIME:   prdata = {16'd0, release_time_reg};
            fvre_pkg::REG_REFRESH_PERIOD: prdata = {16'd0, refresh_period_reg};
            fvre_pkg::REG_LOWEST_NOTE:    prdata = {25'd0, lowest_note_reg};
            fvre_pkg::REG_HIGHEST_NOTE:   prdata = {25'd0, highest_note_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    // ---------------- sequencer and voice state ----------------
    fvre_pkg::state_t state_reg, state_next;

    logic [3:0]  volume_reg    [DRIVEN];
    logic [3:0]  volume_next   [DRIVEN];
    logic        active_reg    [DRIVEN];
    logic        active_next   [DRIVEN];
    logic [4:0]  amount_reg    [DRIVEN];
    logic [4:0]  amount_next   [DRIVEN];
    logic [15:0] period_reg    [DRIVEN];
    logic [15:0] period_next   [DRIVEN];
    logic [15:0] countdown_reg [DRIVEN];
    logic [15:0] countdown_next[DRIVEN];

    logic [IDX_W-1:0] ch_reg, ch_next;      // voice of a note-on / note-off
    logic [IDX_W-1:0] idx_reg, idx_next;    // tick walk position
    logic [6:0]       pitch_reg, pitch_next;
    logic             amt_mode_reg, amt_mode_next; // 1: quotient is a per-step decrement

    // shared divider: dvd shifts out dividend bits and collects the quotient
    logic [DW-1:0] div_dvd_reg, div_dvd_next;
    logic [DW-1:0] div_dvs_reg, div_dvs_next;
    logic [DW-1:0] div_rem_reg, div_rem_next;
    logic [CW-1:0] div_cnt_reg, div_cnt_next;
    logic [DW:0]   div_shift, div_sub;
    logic          div_ge, div_done;

    // output register
    logic       m_valid_reg, m_valid_next;
    logic       m_kind_reg, m_kind_next;
    logic [1:0] m_voice_reg, m_voice_next;
    logic [6:0] m_value_reg, m_value_next;
    logic       m_last_reg, m_last_next;
    logic       out_free;

    // helpers
    logic          note_ok;
    logic [15:0]   rate_steps;
    logic [3:0]    rate_vol;
    logic          rate_ge;
    logic [3:0]    tick_vol_cur, tick_vol_new;
    logic [4:0]    tick_amt;
    logic          tick_zero;
    logic          will_step [DRIVEN];
    logic          later_step;

    assign s_ready = (state_reg == fvre_pkg::S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_voice = m_voice_reg;
    assign m_value = m_value_reg;
    assign m_last  = m_last_reg;

    assign out_free = !m_valid_reg || m_ready;

    // one restoring step per cycle
    assign div_shift = {div_rem_reg, div_dvd_reg[DW-1]};
    assign div_sub   = div_shift - {1'b0, div_dvs_reg};
    assign div_ge    = (div_shift >= {1'b0, div_dvs_reg});
    assign div_done  = (div_cnt_reg == CW'(DW - 1));

    assign note_ok = (s_pitch >= lowest_note_reg) && (s_pitch <= highest_note_reg)
                     && (s_channel < DRIVEN_CH);

    // step count after the first division; zero counts as one
    assign rate_steps = (div_dvd_reg == '0) ? 16'd1 : div_dvd_reg;
    assign rate_vol   = volume_reg[ch_reg];
    assign rate_ge    = ({12'd0, rate_vol} >= rate_steps);

    assign tick_vol_cur = volume_reg[idx_reg];
    assign tick_amt     = amount_reg[idx_reg];
    assign tick_zero    = ({1'b0, tick_vol_cur} <= tick_amt);
    assign tick_vol_new = tick_zero ? 4'd0 : (tick_vol_cur - tick_amt[3:0]);

    // a voice steps on this tick when releasing with its countdown at one or zero;
    // later voices are untouched until visited, so this decides m_last
    always_comb begin
        later_step = 1'b0;
        for (int w = 0; w < DRIVEN; w++) begin
            will_step[w] = active_reg[w] && (countdown_reg[w] <= 16'd1);
            later_step   = later_step || (will_step[w] && (IDX_W'(w) > idx_reg));
        end
    end

    always_comb begin
        state_next    = state_reg;
        ch_next       = ch_reg;
        idx_next      = idx_reg;
        pitch_next    = pitch_reg;
        amt_mode_next = amt_mode_reg;
        div_dvd_next  = div_dvd_reg;
        div_dvs_next  = div_dvs_reg;
        div_rem_next  = div_rem_reg;
        div_cnt_next  = div_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_kind_next   = m_kind_reg;
        m_voice_next  = m_voice_reg;
        m_value_next  = m_value_reg;
        m_last_next   = m_last_reg;
        for (int v = 0; v < DRIVEN; v++) begin
            volume_next[v]    = volume_reg[v];
            active_next[v]    = active_reg[v];
            amount_next[v]    = amount_reg[v];
            period_next[v]    = period_reg[v];
            countdown_next[v] = countdown_reg[v];
        end

        case (state_reg)
            fvre_pkg::S_IDLE: begin
                if (s_valid) begin
                    ch_next    = s_channel[IDX_W-1:0];
                    pitch_next = s_pitch;
                    idx_next   = '0;
                    case (s_mode)
                        fvre_pkg::MODE_NOTE_ON: begin
                            if (note_ok) state_next = fvre_pkg::S_ON_FREQ;
                        end
                        fvre_pkg::MODE_NOTE_OFF: begin
                            if (s_channel < DRIVEN_CH) begin
                                div_dvd_next = release_time_reg;
                                div_dvs_next = (refresh_period_reg == '0) ? 16'd1
                                                                          : refresh_period_reg;
                                div_rem_next = '0;
                                div_cnt_next = '0;
                                state_next   = fvre_pkg::S_DIV1;
                            end
                        end
                        fvre_pkg::MODE_TICK: state_next = fvre_pkg::S_TICK;
                        default: ;
                    endcase
                end
            end

            fvre_pkg::S_ON_FREQ: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = fvre_pkg::KIND_FREQ;
                    m_voice_next = 2'(ch_reg);
                    m_value_next = pitch_reg;
                    m_last_next  = 1'b0;
                    state_next   = fvre_pkg::S_ON_VOL;
                end
            end

            fvre_pkg::S_ON_VOL: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_kind_next         = fvre_pkg::KIND_VOLUME;
                    m_voice_next        = 2'(ch_reg);
                    m_value_next        = {3'd0, fvre_pkg::FULL_VOLUME};
                    m_last_next         = 1'b1;
                    volume_next[ch_reg] = fvre_pkg::FULL_VOLUME;
                    active_next[ch_reg] = 1'b0;
                    state_next          = fvre_pkg::S_IDLE;
                end
            end

            fvre_pkg::S_DIV1, fvre_pkg::S_DIV2: begin
                div_dvd_next = {div_dvd_reg[DW-2:0], div_ge};
                div_rem_next = div_ge ? div_sub[DW-1:0] : div_shift[DW-1:0];
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_done) begin
                    state_next = (state_reg == fvre_pkg::S_DIV1) ? fvre_pkg::S_RATE
                                                                 : fvre_pkg::S_SET;
                end
            end

            fvre_pkg::S_RATE: begin
                if (rate_vol == 4'd0) begin
                    // release from silence just ends
                    active_next[ch_reg] = 1'b0;
                    state_next          = fvre_pkg::S_IDLE;
                end else begin
                    amt_mode_next = rate_ge;
                    div_dvd_next  = rate_ge ? 16'(rate_vol) : rate_steps;
                    div_dvs_next  = rate_ge ? rate_steps : 16'(rate_vol);
                    div_rem_next  = '0;
                    div_cnt_next  = '0;
                    state_next    = fvre_pkg::S_DIV2;
                end
            end

            fvre_pkg::S_SET: begin
                amount_next[ch_reg]    = amt_mode_reg ? div_dvd_reg[4:0] : 5'd1;
                period_next[ch_reg]    = amt_mode_reg ? 16'd1 : div_dvd_reg;
                countdown_next[ch_reg] = amt_mode_reg ? 16'd1 : div_dvd_reg;
                active_next[ch_reg]    = 1'b1;
                state_next             = fvre_pkg::S_IDLE;
            end

            fvre_pkg::S_TICK: begin
                if (!active_reg[idx_reg]) begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == LAST_IDX) state_next = fvre_pkg::S_IDLE;
                end else if (!will_step[idx_reg]) begin
                    countdown_next[idx_reg] = countdown_reg[idx_reg] - 16'd1;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == LAST_IDX) state_next = fvre_pkg::S_IDLE;
                end else if (out_free) begin
                    countdown_next[idx_reg] = period_reg[idx_reg];
                    volume_next[idx_reg]    = tick_vol_new;
                    if (tick_zero) active_next[idx_reg] = 1'b0;
                    m_valid_next = 1'b1;
                    m_kind_next  = fvre_pkg::KIND_VOLUME;
                    m_voice_next = 2'(idx_reg);
                    m_value_next = {3'd0, tick_vol_new};
                    m_last_next  = !later_step;
                    idx_next     = idx_reg + 1'b1;
                    if (idx_reg == LAST_IDX) state_next = fvre_pkg::S_IDLE;
                end
            end

            default: state_next = fvre_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fvre_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
            for (int v = 0; v < DRIVEN; v++) begin
                volume_reg[v]    <= '0;
                active_reg[v]    <= 1'b0;
                amount_reg[v]    <= '0;
                period_reg[v]    <= '0;
                countdown_reg[v] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            for (int v = 0; v < DRIVEN; v++) begin
                volume_reg[v]    <= volume_next[v];
                active_reg[v]    <= active_next[v];
                amount_reg[v]    <= amount_next[v];
                period_reg[v]    <= period_next[v];
                countdown_reg[v] <= countdown_next[v];
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        ch_reg       <= ch_next;
        idx_reg      <= idx_next;
        pitch_reg    <= pitch_next;
        amt_mode_reg <= amt_mode_next;
        div_dvd_reg  <= div_dvd_next;
        div_dvs_reg  <= div_dvs_next;
        div_rem_reg  <= div_rem_next;
        div_cnt_reg  <= div_cnt_next;
        m_kind_reg   <= m_kind_next;
        m_voice_reg  <= m_voice_next;
        m_value_reg  <= m_value_next;
        m_last_reg   <= m_last_next;
    end

endmodule
